// File: rtl/core/isotp_receive_reassembler_defines.svh
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler assertion macros
// Shared property macros for the port checker of the reassembler.
// ----------------------------------------------------------------------------
`ifndef ISOTP_RECEIVE_REASSEMBLER_DEFINES_SVH
`define ISOTP_RECEIVE_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while in reset.
`define ISOTP_RR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while in reset.
`define ISOTP_RR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/isotp_rr_pkg.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler package
// Types, codes and constants shared by the reassembler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isotp_rr_pkg;

    // Field widths.
    localparam int ID_W   = 11;
    localparam int LEN_W  = 12;
    localparam int DATA_W = 64;
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int ERR_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_FRAME    = 2'd0;
    localparam logic [OP_W-1:0] OP_START    = 2'd1;
    localparam logic [OP_W-1:0] OP_DEADLINE = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLOW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FAIL = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SINGLE  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_FIRST   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SEQ     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TIMEOUT = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_REPLY_ID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_VALUE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTIONAL_ID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 3'd7;

    // PCI frame types (upper nibble of byte 0).
    localparam logic [3:0] PCI_SINGLE      = 4'h0;
    localparam logic [3:0] PCI_FIRST       = 4'h1;
    localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

    // Flow-control frame head: clear to send, block size 0, separation 0.
    localparam logic [7:0]  FC_PCI  = 8'h30;
    localparam logic [15:0] FC_ZERO = 16'h0000;

    // Largest payload chunks of single/consecutive and first frames.
    localparam logic [2:0] SF_MAX_LEN  = 3'd7;
    localparam logic [2:0] CF_MAX_LEN  = 3'd7;
    localparam logic [2:0] FF_MAX_LEN  = 3'd6;
    // Byte position of the first payload byte.
    localparam logic [2:0] SF_START = 3'd1;
    localparam logic [2:0] FF_START = 3'd2;

    typedef struct packed {
        logic [ID_W-1:0]  target_id;
        logic [ID_W-1:0]  flow_reply_id;
        logic [LEN_W-1:0] capacity;
        logic [7:0]       pad_value;
        logic [ID_W-1:0]  response_low;
        logic [ID_W-1:0]  response_high;
        logic [ID_W-1:0]  functional_id;
        logic [LEN_W-1:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic             armed;
        logic             started;
        logic [LEN_W-1:0] total_length;
        logic [LEN_W-1:0] bytes_written;
        logic [3:0]       expected_sequence;
    } t_state;

    localparam t_state IDLE_STATE = '{
        armed: 1'b0, started: 1'b0, total_length: '0,
        bytes_written: '0, expected_sequence: 4'd1
    };

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ID_W-1:0]   frame_id;
        logic [DATA_W-1:0] frame_data;
    } t_item;

    // Work list for one item: payload bytes, then flow control, then end.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [2:0]        start;
        logic [2:0]        nbytes;
        logic [LEN_W-1:0]  base;
        logic              flow;
        logic              fin;
        logic [ERR_W-1:0]  err;
        logic [LEN_W-1:0]  length;
    } t_desc;

endpackage

// File: rtl/core/isotp_rr_in_if.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler input channel
// Valid/ready channel that carries one received item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isotp_rr_in_if;
    logic                              valid;
    logic                              ready;
    logic [isotp_rr_pkg::OP_W-1:0]     operation;
    logic [isotp_rr_pkg::ID_W-1:0]     frame_id;
    logic [isotp_rr_pkg::DATA_W-1:0]   frame_data;

    modport source (output valid, output operation, output frame_id,
                    output frame_data, input ready);
    modport sink   (input valid, input operation, input frame_id,
                    input frame_data, output ready);
endinterface

// File: rtl/core/isotp_rr_out_if.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isotp_rr_out_if;
    logic                              valid;
    logic                              ready;
    logic [isotp_rr_pkg::KIND_W-1:0]   out_kind;
    logic [7:0]                        out_byte;
    logic [isotp_rr_pkg::LEN_W-1:0]    byte_index;
    logic [isotp_rr_pkg::ID_W-1:0]     flow_id;
    logic [isotp_rr_pkg::DATA_W-1:0]   flow_frame;
    logic [isotp_rr_pkg::LEN_W-1:0]    message_length;
    logic [isotp_rr_pkg::ERR_W-1:0]    error_code;
    logic                              last;

    modport source (output valid, output out_kind, output out_byte, output byte_index,
                    output flow_id, output flow_frame, output message_length,
                    output error_code, output last, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input byte_index,
                    input flow_id, input flow_frame, input message_length,
                    input error_code, input last, output ready);
endinterface

// File: rtl/core/isotp_rr_decode.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler decoder
// Decodes one registered item against the run state: builds the result
// work list and the next run state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isotp_rr_decode (
    input  isotp_rr_pkg::t_cfg   i_cfg,
    input  isotp_rr_pkg::t_state i_state,
    input  isotp_rr_pkg::t_item  i_item,
    output isotp_rr_pkg::t_desc  o_desc,
    output logic [3:0]           o_count,
    output isotp_rr_pkg::t_state o_state
);

    logic [7:0]                       pci;
    logic [3:0]                       pci_type;
    logic [3:0]                       pci_low;
    logic                             range_mode;
    logic                             id_ok;
    logic [isotp_rr_pkg::LEN_W-1:0]   ff_total;
    logic [2:0]                       ff_chunk;
    logic [isotp_rr_pkg::LEN_W-1:0]   cf_rem;
    logic [2:0]                       cf_chunk;
    logic [isotp_rr_pkg::LEN_W-1:0]   cf_written;

    // Frame header fields.
    assign pci      = i_item.frame_data[63:56];
    assign pci_type = pci[7:4];
    assign pci_low  = pci[3:0];

    // Identifier filter: range match for the functional or base id, else exact.
    assign range_mode = (i_cfg.target_id == i_cfg.functional_id) ||
                        (i_cfg.target_id == i_cfg.response_low);
    assign id_ok = range_mode
                 ? ((i_item.frame_id >= i_cfg.response_low) &&
                    (i_item.frame_id <= i_cfg.response_high))
                 : (i_item.frame_id == i_cfg.target_id);

    // First frame total and its leading chunk.
    assign ff_total = {pci_low, i_item.frame_data[55:48]};
    assign ff_chunk = (ff_total < 12'(isotp_rr_pkg::FF_MAX_LEN))
                    ? ff_total[2:0] : isotp_rr_pkg::FF_MAX_LEN;

    // Consecutive frame chunk limited by what remains of the message.
    assign cf_rem = (i_state.total_length > i_state.bytes_written)
                  ? (i_state.total_length - i_state.bytes_written) : '0;
    assign cf_chunk = (cf_rem > 12'(isotp_rr_pkg::CF_MAX_LEN))
                    ? isotp_rr_pkg::CF_MAX_LEN : cf_rem[2:0];
    assign cf_written = i_state.bytes_written + 12'(cf_chunk);

    // Result count of the work list.
    assign o_count = 4'(o_desc.nbytes) + 4'(o_desc.flow) + 4'(o_desc.fin);

    // Decode of the item against the current run.
    always_comb begin
        o_desc        = '0;
        o_desc.data   = i_item.frame_data;
        o_state       = i_state;
        unique case (i_item.operation)
            isotp_rr_pkg::OP_START: begin
                o_state       = isotp_rr_pkg::IDLE_STATE;
                o_state.armed = 1'b1;
            end
            isotp_rr_pkg::OP_DEADLINE: begin
                if (i_state.armed) begin
                    o_desc.fin = 1'b1;
                    o_desc.err = isotp_rr_pkg::ERR_TIMEOUT;
                    o_state    = isotp_rr_pkg::IDLE_STATE;
                end
            end
            isotp_rr_pkg::OP_FRAME: begin
                if (i_state.armed && id_ok) begin
                    priority if (pci_type == isotp_rr_pkg::PCI_SINGLE) begin
                        o_desc.fin = 1'b1;
                        if ((pci_low == 4'd0) || pci_low[3] ||
                            (12'(pci_low) > i_cfg.capacity)) begin
                            o_desc.err = isotp_rr_pkg::ERR_SINGLE;
                        end else begin
                            o_desc.start  = isotp_rr_pkg::SF_START;
                            o_desc.nbytes = pci_low[2:0];
                            o_desc.length = 12'(pci_low);
                        end
                        o_state = isotp_rr_pkg::IDLE_STATE;
                    end else if (pci_type == isotp_rr_pkg::PCI_FIRST) begin
                        if ((ff_total == '0) || (ff_total > i_cfg.capacity) ||
                            (ff_total > i_cfg.max_payload)) begin
                            o_desc.fin = 1'b1;
                            o_desc.err = isotp_rr_pkg::ERR_FIRST;
                            o_state    = isotp_rr_pkg::IDLE_STATE;
                        end else begin
                            o_desc.start  = isotp_rr_pkg::FF_START;
                            o_desc.nbytes = ff_chunk;
                            o_desc.flow   = 1'b1;
                            if (12'(ff_chunk) >= ff_total) begin
                                // Short first frame completes at once.
                                o_desc.fin    = 1'b1;
                                o_desc.length = ff_total;
                                o_state       = isotp_rr_pkg::IDLE_STATE;
                            end else begin
                                o_state.started           = 1'b1;
                                o_state.total_length      = ff_total;
                                o_state.bytes_written     = 12'(ff_chunk);
                                o_state.expected_sequence = 4'd1;
                            end
                        end
                    end else if ((pci_type == isotp_rr_pkg::PCI_CONSECUTIVE) &&
                                 i_state.started) begin
                        if (pci_low != i_state.expected_sequence) begin
                            o_desc.fin = 1'b1;
                            o_desc.err = isotp_rr_pkg::ERR_SEQ;
                            o_state    = isotp_rr_pkg::IDLE_STATE;
                        end else begin
                            o_desc.start  = isotp_rr_pkg::SF_START;
                            o_desc.nbytes = cf_chunk;
                            o_desc.base   = i_state.bytes_written;
                            o_state.bytes_written     = cf_written;
                            o_state.expected_sequence = i_state.expected_sequence + 4'd1;
                            if (cf_written >= i_state.total_length) begin
                                o_desc.fin    = 1'b1;
                                o_desc.length = i_state.total_length;
                                o_state       = isotp_rr_pkg::IDLE_STATE;
                            end
                        end
                    end else begin
                        // Flow control, unknown type or early consecutive frame.
                        o_state = i_state;
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// File: rtl/core/isotp_rr_emit.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler result emitter
// Holds one work list and steps through it, one result per transfer,
// into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isotp_rr_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  isotp_rr_pkg::t_desc            i_desc,
    input  logic [3:0]                     i_count,
    input  logic [isotp_rr_pkg::ID_W-1:0]  i_flow_reply_id,
    input  logic [7:0]                     i_pad_value,
    output logic                           o_take,
    isotp_rr_out_if.source                 o_res
);

    logic                r_busy;
    logic [3:0]          r_cnt;
    logic [2:0]          r_step;
    isotp_rr_pkg::t_desc r_desc;
    logic                r_out_valid;

    logic                out_free;
    logic                move;
    logic                step_last;
    logic                is_byte;
    logic                is_flow;
    logic [2:0]          sel;

    logic [isotp_rr_pkg::KIND_W-1:0] n_kind;
    logic [7:0]                      n_byte;
    logic [isotp_rr_pkg::LEN_W-1:0]  n_index;
    logic [isotp_rr_pkg::ID_W-1:0]   n_flow_id;
    logic [isotp_rr_pkg::DATA_W-1:0] n_flow_frame;
    logic [isotp_rr_pkg::LEN_W-1:0]  n_length;
    logic [isotp_rr_pkg::ERR_W-1:0]  n_err;

    // Step control: a result moves whenever the output stage is free.
    assign out_free  = !r_out_valid || o_res.ready;
    assign move      = r_busy && out_free;
    assign step_last = ((4'(r_step) + 4'd1) == r_cnt);
    assign o_take    = !r_busy || (move && step_last);

    // Result of the current step.
    assign is_byte = (r_step < r_desc.nbytes);
    assign is_flow = !is_byte && r_desc.flow && (r_step == r_desc.nbytes);
    assign sel     = r_desc.start + r_step;

    always_comb begin
        n_kind       = isotp_rr_pkg::KIND_BYTE;
        n_byte       = '0;
        n_index      = '0;
        n_flow_id    = '0;
        n_flow_frame = '0;
        n_length     = '0;
        n_err        = isotp_rr_pkg::ERR_NONE;
        if (is_byte) begin
            n_byte  = r_desc.data[{3'd7 - sel, 3'b000} +: 8];
            n_index = r_desc.base + 12'(r_step);
        end else if (is_flow) begin
            n_kind       = isotp_rr_pkg::KIND_FLOW;
            n_flow_id    = i_flow_reply_id;
            n_flow_frame = {isotp_rr_pkg::FC_PCI, isotp_rr_pkg::FC_ZERO, {5{i_pad_value}}};
        end else if (r_desc.err != isotp_rr_pkg::ERR_NONE) begin
            n_kind = isotp_rr_pkg::KIND_FAIL;
            n_err  = r_desc.err;
        end else begin
            n_kind   = isotp_rr_pkg::KIND_DONE;
            n_length = r_desc.length;
        end
    end

    // Control registers of the work list and the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= i_count;
                r_step <= '0;
            end else if (move) begin
                if (step_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
        if (move) begin
            o_res.out_kind       <= n_kind;
            o_res.out_byte       <= n_byte;
            o_res.byte_index     <= n_index;
            o_res.flow_id        <= n_flow_id;
            o_res.flow_frame     <= n_flow_frame;
            o_res.message_length <= n_length;
            o_res.error_code     <= n_err;
            o_res.last           <= step_last;
        end
    end

    assign o_res.valid = r_out_valid;

endmodule

// File: rtl/core/isotp_receive_reassembler.sv
// Items pass the input register, the emitter work list and the output stage;
// an item with no results skips the emitter. One with n results (up to eight)
// holds the emitter, one result per cycle while the output is not stalled.
// Reset (synchronous, active low) disarms the run, empties the input and
// output stages and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler
// Reassembles one ISO-TP message from received CAN frames into payload
// byte, flow-control, complete and failed results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isotp_receive_reassembler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [isotp_rr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [isotp_rr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    isotp_rr_in_if.sink                          i_item,
    isotp_rr_out_if.source                       o_result
);

    isotp_rr_pkg::t_cfg   r_cfg;
    isotp_rr_pkg::t_state r_state;
    isotp_rr_pkg::t_item  r_in;
    logic                 r_in_valid;

    isotp_rr_pkg::t_desc  desc;
    isotp_rr_pkg::t_state n_state;
    logic [3:0]           count;
    logic                 em_take;
    logic                 advance;
    logic                 load;

    // Input stage moves on when its results fit into the emitter.
    assign advance      = r_in_valid && ((count == 4'd0) || em_take);
    assign load         = advance && (count != 4'd0);
    assign i_item.ready = !r_in_valid || advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_id     <= 11'd2024;
            r_cfg.flow_reply_id <= 11'd2016;
            r_cfg.capacity      <= 12'd4095;
            r_cfg.pad_value     <= 8'd0;
            r_cfg.response_low  <= 11'd2024;
            r_cfg.response_high <= 11'd2031;
            r_cfg.functional_id <= 11'd2015;
            r_cfg.max_payload   <= 12'd4095;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                isotp_rr_pkg::CFG_TARGET_ID:     r_cfg.target_id     <= i_cfg_data[10:0];
                isotp_rr_pkg::CFG_FLOW_REPLY_ID: r_cfg.flow_reply_id <= i_cfg_data[10:0];
                isotp_rr_pkg::CFG_CAPACITY:      r_cfg.capacity      <= i_cfg_data;
                isotp_rr_pkg::CFG_PAD_VALUE:     r_cfg.pad_value     <= i_cfg_data[7:0];
                isotp_rr_pkg::CFG_RESPONSE_LOW:  r_cfg.response_low  <= i_cfg_data[10:0];
                isotp_rr_pkg::CFG_RESPONSE_HIGH: r_cfg.response_high <= i_cfg_data[10:0];
                isotp_rr_pkg::CFG_FUNCTIONAL_ID: r_cfg.functional_id <= i_cfg_data[10:0];
                isotp_rr_pkg::CFG_MAX_PAYLOAD:   r_cfg.max_payload   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= isotp_rr_pkg::IDLE_STATE;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.operation  <= i_item.operation;
            r_in.frame_id   <= i_item.frame_id;
            r_in.frame_data <= i_item.frame_data;
        end
    end

    isotp_rr_decode u_decode (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_desc  (desc),
        .o_count (count),
        .o_state (n_state)
    );

    isotp_rr_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_desc          (desc),
        .i_count         (count),
        .i_flow_reply_id (r_cfg.flow_reply_id),
        .i_pad_value     (r_cfg.pad_value),
        .o_take          (em_take),
        .o_res           (o_result)
    );

endmodule

// File: rtl/core/isotp_rr_checker.sv
// ----------------------------------------------------------------------------
// ISO-TP receive reassembler port checker
// Watches the result channel of the reassembler and checks its results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "isotp_receive_reassembler_defines.svh"

module isotp_rr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [isotp_rr_pkg::KIND_W-1:0]     i_out_kind,
    input logic [7:0]                          i_out_byte,
    input logic [isotp_rr_pkg::LEN_W-1:0]      i_out_index,
    input logic [isotp_rr_pkg::DATA_W-1:0]     i_out_flow_frame,
    input logic [isotp_rr_pkg::LEN_W-1:0]      i_out_length,
    input logic [isotp_rr_pkg::ERR_W-1:0]      i_out_error,
    input logic                                i_out_last
);

    // A stalled result transfer keeps its contents.
    `ISOTP_RR_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_byte) && $stable(i_out_index) && $stable(i_out_last), "result changed while stalled")

    // A failure ends the item's results and carries an error code.
    `ISOTP_RR_ASSERT_SAME(a_fail_last, i_out_valid && (i_out_kind == isotp_rr_pkg::KIND_FAIL), i_out_last && (i_out_error != isotp_rr_pkg::ERR_NONE), "failed result not final or without code")

    // A completion ends the item's results with a nonzero length.
    `ISOTP_RR_ASSERT_SAME(a_done_last, i_out_valid && (i_out_kind == isotp_rr_pkg::KIND_DONE), i_out_last && (i_out_error == isotp_rr_pkg::ERR_NONE) && (i_out_length != '0), "bad complete result")

    // A flow-control result carries clear-to-send with zero block and gap.
    `ISOTP_RR_ASSERT_SAME(a_flow_frame, i_out_valid && (i_out_kind == isotp_rr_pkg::KIND_FLOW), (i_out_flow_frame[63:56] == isotp_rr_pkg::FC_PCI) && (i_out_flow_frame[55:40] == isotp_rr_pkg::FC_ZERO), "bad flow-control frame")

endmodule

bind isotp_receive_reassembler isotp_rr_checker u_isotp_rr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_out_kind       (o_result.out_kind),
    .i_out_byte       (o_result.out_byte),
    .i_out_index      (o_result.byte_index),
    .i_out_flow_frame (o_result.flow_frame),
    .i_out_length     (o_result.message_length),
    .i_out_error      (o_result.error_code),
    .i_out_last       (o_result.last)
);
